FILE: rtl/reaction_dependency_scan_defines.svh
// Assertion macros for the reaction dependency scan RTL, used by rds_seq.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef REACTION_DEPENDENCY_SCAN_DEFINES_SVH
`define REACTION_DEPENDENCY_SCAN_DEFINES_SVH

// Plain property, checked at every clock edge outside reset.
`define RDS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define RDS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RDS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rds_pkg.sv
// Package for the reaction dependency scan: default parameters, fixed port
// widths, command codes, sequencer states and the output word struct. No dependencies.
package rds_pkg;

  localparam int unsigned MaxReactionsDef = 64;
  localparam int unsigned SpeciesBitsDef  = 16;
  localparam int unsigned SlotsPerSideDef = 2;

  localparam int unsigned SlotW      = 6;
  localparam int unsigned SpeciesInW = 16;
  localparam int unsigned SideTotalW = 2;
  localparam int unsigned RegW       = 7;
  localparam int unsigned TotalW     = 7;

  localparam logic [RegW-1:0] CountReset = 7'd64;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOUCH,
    ST_COUNT,
    ST_EMIT,
    ST_NONE
  } rds_state_e;

  // Request from the sequencer to load the output register.
  typedef struct packed {
    logic              load;
    logic [SlotW-1:0]  slot;
    logic [TotalW-1:0] total;
    logic              none;
    logic              last;
  } rds_word_t;

endpackage

FILE: rtl/rds_table.sv
// Reaction table: one row per reaction, one write port, one read port with
// registered, enabled read data. Depends on nothing but its parameters.
module rds_table #(
  parameter int unsigned MAX_REACTIONS = 64,
  parameter int unsigned ROW_W         = 68
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(MAX_REACTIONS)-1:0] wr_addr_i,
  input  logic [ROW_W-1:0]                 wr_row_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(MAX_REACTIONS)-1:0] rd_addr_i,
  output logic [ROW_W-1:0]                 rd_row_o
);

  logic [ROW_W-1:0] mem [MAX_REACTIONS];
  logic [ROW_W-1:0] rd_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
  end

  // Hold read data while the scan is stalled.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem[rd_addr_i];
    end
  end

  assign rd_row_o = rd_row_q;

endmodule

FILE: rtl/rds_match.sv
// Shared compare unit: holds the species touched by the queried reaction and
// checks each scanned row's reactants against them. Depends on row layout only.
module rds_match #(
  parameter int unsigned SPECIES_BITS   = 16,
  parameter int unsigned SLOTS_PER_SIDE = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                capture_i,
  input  logic                slot_ok_i,
  input  logic [2*($clog2(SLOTS_PER_SIDE+1)) + 2*SLOTS_PER_SIDE*SPECIES_BITS-1:0] rd_row_i,
  output logic                match_o
);

  localparam int unsigned CntW  = $clog2(SLOTS_PER_SIDE + 1);
  localparam int unsigned Touch = 2 * SLOTS_PER_SIDE;

  logic [SLOTS_PER_SIDE-1:0][SPECIES_BITS-1:0] row_rs;
  logic [SLOTS_PER_SIDE-1:0][SPECIES_BITS-1:0] row_ps;
  logic [CntW-1:0]                             row_rc;
  logic [CntW-1:0]                             row_pc;

  logic [Touch-1:0][SPECIES_BITS-1:0] tch_q, tch_d;
  logic [Touch-1:0]                   tch_vld_q, tch_vld_d;

  assign {row_pc, row_rc, row_ps, row_rs} = rd_row_i;

  // Capture the reactants and products of the queried row.
  always_comb begin
    tch_d     = tch_q;
    tch_vld_d = tch_vld_q;
    if (capture_i) begin
      for (int k = 0; k < SLOTS_PER_SIDE; k++) begin
        tch_d[k]                      = row_rs[k];
        tch_d[SLOTS_PER_SIDE + k]     = row_ps[k];
        tch_vld_d[k]                  = slot_ok_i && (CntW'(k) < row_rc);
        tch_vld_d[SLOTS_PER_SIDE + k] = slot_ok_i && (CntW'(k) < row_pc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tch_vld_q <= '0;
    end else begin
      tch_vld_q <= tch_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tch_q <= tch_d;
  end

  // Any live reactant of the scanned row equal to any touched species.
  always_comb begin
    match_o = 1'b0;
    for (int l = 0; l < SLOTS_PER_SIDE; l++) begin
      for (int m = 0; m < Touch; m++) begin
        if ((CntW'(l) < row_rc) && tch_vld_q[m] && (row_rs[l] == tch_q[m])) begin
          match_o = 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/rds_seq.sv
// Scan sequencer: reads the queried row, runs a counting pass and an emitting
// pass over the table. Depends on rds_pkg and the assertion macro header.
`include "reaction_dependency_scan_defines.svh"

module rds_seq
  import rds_pkg::*;
#(
  parameter int unsigned MAX_REACTIONS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               cmd_i,
  input  logic [SlotW-1:0]                   slot_i,
  input  logic                               slot_ok_i,
  input  logic [$clog2(MAX_REACTIONS+1)-1:0] limit_i,
  input  logic                               match_i,
  input  logic                               out_free_i,
  output logic                               busy_o,
  output logic                               rd_en_o,
  output logic [$clog2(MAX_REACTIONS)-1:0]   rd_addr_o,
  output logic                               capture_o,
  output logic                               slot_ok_o,
  output rds_word_t                          req_o
);

  localparam int unsigned IdxW = $clog2(MAX_REACTIONS);
  localparam int unsigned CntW = $clog2(MAX_REACTIONS + 1);

  rds_state_e      state_q, state_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [CntW-1:0] chk_idx_q, chk_idx_d;
  logic            chk_vld_q, chk_vld_d;
  logic [CntW-1:0] found_q, found_d;
  logic [CntW-1:0] emitted_q, emitted_d;
  logic            slot_ok_q, slot_ok_d;

  logic query_acc;
  logic advance;
  logic issue;
  logic hit;
  logic pass_done;
  logic is_last;

  assign query_acc = in_valid_i && (state_q == ST_IDLE) && (cmd_i == CMD_QUERY);
  assign advance   = (state_q == ST_COUNT) || ((state_q == ST_EMIT) && out_free_i);
  assign issue     = advance && (scan_q < limit_i);
  assign hit       = advance && chk_vld_q && match_i;
  assign pass_done = (scan_q == limit_i) && !chk_vld_q;
  assign is_last   = (emitted_q == found_q - CntW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (query_acc) state_d = ST_TOUCH;
      ST_TOUCH: state_d = ST_COUNT;
      ST_COUNT: begin
        if (pass_done) begin
          state_d = (found_q == '0) ? ST_NONE : ST_EMIT;
        end
      end
      ST_EMIT:  if (hit && is_last) state_d = ST_IDLE;
      ST_NONE:  if (out_free_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and scan counters.
  always_comb begin
    scan_d    = scan_q;
    chk_idx_d = chk_idx_q;
    chk_vld_d = chk_vld_q;
    found_d   = found_q;
    emitted_d = emitted_q;
    slot_ok_d = slot_ok_q;
    rd_en_o   = 1'b0;
    rd_addr_o = scan_q[IdxW-1:0];
    capture_o = 1'b0;
    req_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          rd_en_o   = 1'b1;
          rd_addr_o = slot_ok_i ? IdxW'(slot_i) : '0;
          slot_ok_d = slot_ok_i;
        end
      end
      ST_TOUCH: begin
        capture_o = 1'b1;
        scan_d    = '0;
        chk_vld_d = 1'b0;
        found_d   = '0;
        emitted_d = '0;
      end
      ST_COUNT, ST_EMIT: begin
        rd_en_o = issue;
        if (advance) begin
          chk_vld_d = issue;
          chk_idx_d = scan_q;
          if (issue) scan_d = scan_q + CntW'(1);
        end
        if (state_q == ST_COUNT) begin
          if (hit) found_d = found_q + CntW'(1);
          if (pass_done) begin
            scan_d    = '0;
            chk_vld_d = 1'b0;
          end
        end else if (hit) begin
          req_o.load  = 1'b1;
          req_o.slot  = SlotW'(chk_idx_q);
          req_o.total = TotalW'(found_q);
          req_o.none  = 1'b0;
          req_o.last  = is_last;
          emitted_d   = emitted_q + CntW'(1);
        end
      end
      ST_NONE: begin
        if (out_free_i) begin
          req_o.load = 1'b1;
          req_o.none = 1'b1;
          req_o.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scan_q    <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= '0;
      emitted_q <= '0;
      slot_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      chk_vld_q <= chk_vld_d;
      found_q   <= found_d;
      emitted_q <= emitted_d;
      slot_ok_q <= slot_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign slot_ok_o = slot_ok_q;

  `RDS_ASSERT_IMPL(a_req_when_free, req_o.load, out_free_i, "word pushed into a full output register")
  `RDS_ASSERT_IMPL(a_emit_bounded, state_q == ST_EMIT, emitted_q < found_q, "more words emitted than dependents counted")
  `RDS_ASSERT_IMPL(a_scan_bounded, state_q == ST_COUNT || state_q == ST_EMIT, scan_q <= limit_i, "scan index ran past the table limit")
  `RDS_ASSERT_NEXT(a_last_ends_query, req_o.load && req_o.last, state_q == ST_IDLE, "query still busy after its last word")

endmodule

FILE: rtl/reaction_dependency_scan.sv
// Reaction dependency scan, top level: config register, load path, output
// register. Depends on rds_pkg, rds_table, rds_match and rds_seq.
//
// A load word (cmd 0) writes one reaction row in the cycle it is accepted and
// gives no result; the block is ready again at once. A query word (cmd 1)
// reads the queried row, then makes two passes over entries 0 to limit-1,
// where limit is reaction_count clipped to MAX_REACTIONS: a counting pass to
// get the dependent total that every result word carries, then an emitting
// pass that sends the dependents in ascending order with last on the final
// one, or a single none_found word when nothing depends on the query. The
// table has one read port and yields one row per cycle, except that the
// emitting pass freezes while the output register is stalled; it stops
// after the last dependent. in_stall_o stays high for the whole query. The
// output register is separate from the sequencer, so a new word is taken
// while the final result of the previous query waits. Rows never loaded
// read as garbage; scan only loaded rows. reaction_count may be written
// only while no query is in progress.
module reaction_dependency_scan
  import rds_pkg::*;
#(
  parameter int unsigned MAX_REACTIONS  = MaxReactionsDef,
  parameter int unsigned SPECIES_BITS   = SpeciesBitsDef,
  parameter int unsigned SLOTS_PER_SIDE = SlotsPerSideDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [RegW-1:0]       cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [SlotW-1:0]      reaction_slot_i,
  input  logic [SideTotalW-1:0] reactant_total_i,
  input  logic [SpeciesInW-1:0] reactant_first_i,
  input  logic [SpeciesInW-1:0] reactant_second_i,
  input  logic [SideTotalW-1:0] product_total_i,
  input  logic [SpeciesInW-1:0] product_first_i,
  input  logic [SpeciesInW-1:0] product_second_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SlotW-1:0]      dependent_slot_o,
  output logic [TotalW-1:0]     dependent_total_o,
  output logic                  none_found_o,
  output logic                  last_o
);

  localparam int unsigned IdxW  = $clog2(MAX_REACTIONS);
  localparam int unsigned CntW  = $clog2(MAX_REACTIONS + 1);
  localparam int unsigned SideW = $clog2(SLOTS_PER_SIDE + 1);
  localparam int unsigned RowW  = 2 * SideW + 2 * SLOTS_PER_SIDE * SPECIES_BITS;

  // reaction_count register
  logic [RegW-1:0] count_q;
  logic [CntW-1:0] limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Clip the scan length to the table depth.
  always_comb begin
    if (32'(count_q) > MAX_REACTIONS) begin
      limit = CntW'(MAX_REACTIONS);
    end else begin
      limit = CntW'(count_q);
    end
  end

  // Input handshake and load path
  logic busy;
  logic in_acc;
  logic slot_ok;
  logic wr_en;

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !busy;
  assign slot_ok    = (32'(reaction_slot_i) < MAX_REACTIONS);
  assign wr_en      = in_acc && (cmd_i == CMD_LOAD) && slot_ok;

  logic [SLOTS_PER_SIDE-1:0][SPECIES_BITS-1:0] wr_rs;
  logic [SLOTS_PER_SIDE-1:0][SPECIES_BITS-1:0] wr_ps;
  logic [SideW-1:0]                            wr_rc;
  logic [SideW-1:0]                            wr_pc;
  logic [RowW-1:0]                             wr_row;

  // Saturate the side counts, zero the species slots beyond the second.
  always_comb begin
    wr_rc = (32'(reactant_total_i) > SLOTS_PER_SIDE) ? SideW'(SLOTS_PER_SIDE)
                                                     : SideW'(reactant_total_i);
    wr_pc = (32'(product_total_i) > SLOTS_PER_SIDE) ? SideW'(SLOTS_PER_SIDE)
                                                    : SideW'(product_total_i);
    for (int k = 0; k < SLOTS_PER_SIDE; k++) begin
      if (k == 0) begin
        wr_rs[k] = SPECIES_BITS'(reactant_first_i);
        wr_ps[k] = SPECIES_BITS'(product_first_i);
      end else if (k == 1) begin
        wr_rs[k] = SPECIES_BITS'(reactant_second_i);
        wr_ps[k] = SPECIES_BITS'(product_second_i);
      end else begin
        wr_rs[k] = '0;
        wr_ps[k] = '0;
      end
    end
  end

  assign wr_row = {wr_pc, wr_rc, wr_ps, wr_rs};

  // Table, compare unit and sequencer
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [RowW-1:0] rd_row;
  logic            capture;
  logic            q_slot_ok;
  logic            match;
  logic            out_free;
  rds_word_t       req;

  rds_table #(
    .MAX_REACTIONS (MAX_REACTIONS),
    .ROW_W         (RowW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (IdxW'(reaction_slot_i)),
    .wr_row_i  (wr_row),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row)
  );

  rds_match #(
    .SPECIES_BITS   (SPECIES_BITS),
    .SLOTS_PER_SIDE (SLOTS_PER_SIDE)
  ) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .capture_i (capture),
    .slot_ok_i (q_slot_ok),
    .rd_row_i  (rd_row),
    .match_o   (match)
  );

  rds_seq #(
    .MAX_REACTIONS (MAX_REACTIONS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .slot_i     (reaction_slot_i),
    .slot_ok_i  (slot_ok),
    .limit_i    (limit),
    .match_i    (match),
    .out_free_i (out_free),
    .busy_o     (busy),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .capture_o  (capture),
    .slot_ok_o  (q_slot_ok),
    .req_o      (req)
  );

  // Output register: take a new word when empty or being drained.
  logic              out_vld_q, out_vld_d;
  logic [SlotW-1:0]  out_slot_q;
  logic [TotalW-1:0] out_total_q;
  logic              out_none_q;
  logic              out_last_q;

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (req.load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.load) begin
      out_slot_q  <= req.slot;
      out_total_q <= req.total;
      out_none_q  <= req.none;
      out_last_q  <= req.last;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign dependent_slot_o  = out_slot_q;
  assign dependent_total_o = out_total_q;
  assign none_found_o      = out_none_q;
  assign last_o            = out_last_q;

endmodule
